// File: rtl/dpt_pkg.sv
// shared types, constants and command format of the deadline/priority task picker
// no dependencies; every other file of the block imports it
package dpt_pkg;

    localparam int TASK_COUNT  = 8;
    localparam int IDX_W       = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int SLOT_W      = 3;
    localparam int LEVEL_W     = 4;
    localparam int TIME_W      = 32;
    localparam int WIN_W       = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIN_W-1:0] FIRE_WINDOW_RESET = 16'd5000;

    // request kind codes on the input port
    localparam logic [1:0] KIND_DEFINE   = 2'd0;
    localparam logic [1:0] KIND_RESCHED  = 2'd1;
    localparam logic [1:0] KIND_SCHEDULE = 2'd2;

    typedef enum logic [1:0] {
        OP_DEFINE,
        OP_RESCHED,
        OP_SCHED
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN0,
        ST_SCAN1,
        ST_FINISH
    } t_eng_state;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   slot;
        logic               valid;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  due;
        logic               never;
        logic [TIME_W-1:0]  estimate;
        logic [TIME_W-1:0]  now;
    } t_cmd;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/deadline_priority_task_picker_core.sv
// top level of the deadline/priority task picker: front end, queue, engine, window register
// depends on dpt_pkg, dpt_front, dpt_queue and dpt_engine
//
// Keeps a table of TASK_COUNT tasks and answers schedule requests with one
// result each; define and reschedule requests update the table and give no
// result, reserved kinds are dropped. For a schedule request the engine reads
// the table through a single port, one entry a cycle, first looking for the
// earliest priority-zero deadline and then for an overdue higher-level task
// that still fits ahead of it. A two-entry request queue lets the input side
// keep accepting while the engine works, and the result register lets the
// engine scan the next request while a result still waits downstream.
// The fire window register resets to 5000 us and is written through the
// configuration port, which is always ready; write it only while the block
// is idle.
module deadline_priority_task_picker_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_kind,
    input  logic [dpt_pkg::SLOT_W-1:0]  i_task_slot,
    input  logic                        i_slot_valid,
    input  logic [dpt_pkg::LEVEL_W-1:0] i_task_level,
    input  logic [dpt_pkg::TIME_W-1:0]  i_due_time,
    input  logic                        i_due_never,
    input  logic [dpt_pkg::TIME_W-1:0]  i_run_estimate,
    input  logic [dpt_pkg::TIME_W-1:0]  i_current_time,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic                        o_fire,
    output logic [dpt_pkg::SLOT_W-1:0]  o_picked_slot,
    output logic [dpt_pkg::WIN_W-1:0]   o_wait_us,
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dpt_pkg::WIN_W-1:0]   i_cfg_data
);
    import dpt_pkg::*;

    logic [WIN_W-1:0] r_fire_window;
    t_cmd             front_cmd;
    t_cmd             q_head;
    t_q_stat          q_stat;
    logic             front_push;
    logic             eng_pop;

    // fire window register, written whenever a config request arrives
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fire_window <= FIRE_WINDOW_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_fire_window <= i_cfg_data;
            end
        end
    end

    // front end: decode, reschedule raise, drop of ignored requests
    dpt_front u_front (
        .i_kind         (i_kind),
        .i_task_slot    (i_task_slot),
        .i_slot_valid   (i_slot_valid),
        .i_task_level   (i_task_level),
        .i_due_time     (i_due_time),
        .i_due_never    (i_due_never),
        .i_run_estimate (i_run_estimate),
        .i_current_time (i_current_time),
        .i_in_valid     (i_in_valid),
        .i_q_stat       (q_stat),
        .o_in_stall     (o_in_stall),
        .o_push         (front_push),
        .o_cmd          (front_cmd)
    );

    // decoupling queue between front end and engine
    dpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (eng_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // engine: task table, scans, result register
    dpt_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_q_stat      (q_stat),
        .o_pop         (eng_pop),
        .i_window      (r_fire_window),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found),
        .o_fire        (o_fire),
        .o_picked_slot (o_picked_slot),
        .o_wait_us     (o_wait_us)
    );

endmodule

// File: rtl/dpt_front.sv
// front end: decodes requests, applies the reschedule raise, drops ignored ones
// depends on dpt_pkg
module dpt_front (
    input  logic [1:0]                  i_kind,
    input  logic [dpt_pkg::SLOT_W-1:0]  i_task_slot,
    input  logic                        i_slot_valid,
    input  logic [dpt_pkg::LEVEL_W-1:0] i_task_level,
    input  logic [dpt_pkg::TIME_W-1:0]  i_due_time,
    input  logic                        i_due_never,
    input  logic [dpt_pkg::TIME_W-1:0]  i_run_estimate,
    input  logic [dpt_pkg::TIME_W-1:0]  i_current_time,
    input  logic                        i_in_valid,
    input  dpt_pkg::t_q_stat            i_q_stat,
    output logic                        o_in_stall,
    output logic                        o_push,
    output dpt_pkg::t_cmd               o_cmd
);
    import dpt_pkg::*;

    logic              slot_ok;
    logic              keep;
    logic [TIME_W-1:0] late;

    assign slot_ok = (32'(i_task_slot) < 32'(TASK_COUNT));
    assign late    = i_due_time - i_current_time;

    always_comb begin
        o_cmd.op       = OP_SCHED;
        o_cmd.slot     = IDX_W'(i_task_slot);
        o_cmd.valid    = i_slot_valid;
        o_cmd.level    = i_task_level;
        o_cmd.due      = i_due_time;
        o_cmd.never    = i_due_never;
        o_cmd.estimate = i_run_estimate;
        o_cmd.now      = i_current_time;
        keep           = 1'b0;
        unique case (i_kind)
            KIND_DEFINE: begin
                o_cmd.op = OP_DEFINE;
                keep     = slot_ok;
            end
            KIND_RESCHED: begin
                o_cmd.op = OP_RESCHED;
                keep     = slot_ok;
                // a past due time is raised to now
                if (!i_due_never && late[TIME_W-1]) begin
                    o_cmd.due = i_current_time;
                end
            end
            KIND_SCHEDULE: begin
                o_cmd.op = OP_SCHED;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full && keep;

endmodule

// File: rtl/dpt_queue.sv
// short show-ahead command queue between front end and engine
// depends on dpt_pkg
module dpt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dpt_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output dpt_pkg::t_cmd    o_head,
    output dpt_pkg::t_q_stat o_stat
);
    import dpt_pkg::*;

    t_cmd              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/dpt_engine.sv
// back end: task table, two scan passes per schedule request, result register
// depends on dpt_pkg
module dpt_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dpt_pkg::t_cmd               i_head,
    input  dpt_pkg::t_q_stat            i_q_stat,
    output logic                        o_pop,
    input  logic [dpt_pkg::WIN_W-1:0]   i_window,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic                        o_found,
    output logic                        o_fire,
    output logic [dpt_pkg::SLOT_W-1:0]  o_picked_slot,
    output logic [dpt_pkg::WIN_W-1:0]   o_wait_us
);
    import dpt_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_COUNT - 1);

    // task table, one read port at the scan index
    logic [TASK_COUNT-1:0] r_ent_valid;
    logic [LEVEL_W-1:0]    r_ent_level [TASK_COUNT];
    logic [TIME_W-1:0]     r_ent_due   [TASK_COUNT];
    logic                  r_ent_never [TASK_COUNT];
    logic [TIME_W-1:0]     r_ent_est   [TASK_COUNT];

    t_eng_state r_state, n_state;
    logic [IDX_W-1:0]   r_idx;
    logic [TIME_W-1:0]  r_now;
    logic               r_have0, r_have1;
    logic [IDX_W-1:0]   r_p0, r_p1;
    logic [TIME_W-1:0]  r_b0_due, r_b1_due;
    logic [LEVEL_W-1:0] r_b1_lvl;
    logic [TIME_W-1:0]  r_slack;   // deadline pick due minus now
    logic [TIME_W-1:0]  r_b1_wait;
    logic               r_out_valid;
    logic               r_found, r_fire;
    logic [SLOT_W-1:0]  r_slot;
    logic [WIN_W-1:0]   r_wait;

    logic               cur_valid, cur_never;
    logic [LEVEL_W-1:0] cur_lvl;
    logic [TIME_W-1:0]  cur_due, cur_est;
    logic [TIME_W-1:0]  d_b0, d_b1, d_now, d_fit;
    logic               take0, take1, cand0, cand1;
    logic               last_idx, load_out, accept_cmd;
    logic [TIME_W-1:0]  fin_wait;
    logic               fin_fire, fin_found;

    assign cur_valid = r_ent_valid[r_idx];
    assign cur_never = r_ent_never[r_idx];
    assign cur_lvl   = r_ent_level[r_idx];
    assign cur_due   = r_ent_due[r_idx];
    assign cur_est   = r_ent_est[r_idx];
    assign last_idx  = (r_idx == IDX_LAST);

    assign d_b0  = r_b0_due - cur_due;
    assign d_b1  = r_b1_due - cur_due;
    assign d_now = cur_due - r_now;
    assign d_fit = r_slack - cur_est;

    assign cand0 = cur_valid && !cur_never && (cur_lvl == '0);
    assign cand1 = cur_valid && !cur_never && (cur_lvl != '0);

    // earlier due wins, ties keep the lower index
    assign take0 = cand0 && (!r_have0 || (!d_b0[TIME_W-1] && d_b0 != '0));

    always_comb begin
        take1 = 1'b0;
        if (cand1 && (d_now[TIME_W-1] || d_now == '0)
                && (!r_have0 || (!d_fit[TIME_W-1] && d_fit != '0))) begin
            take1 = !r_have1 || (r_b1_lvl > cur_lvl)
                 || ((r_b1_lvl == cur_lvl) && !d_b1[TIME_W-1] && d_b1 != '0);
        end
    end

    assign fin_found = r_have0 || r_have1;
    assign fin_wait  = r_have1 ? r_b1_wait : r_slack;
    assign fin_fire  = fin_found
                    && (fin_wait[TIME_W-1] || (fin_wait < TIME_W'(i_window)));

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        accept_cmd = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop      = 1'b1;
                    accept_cmd = 1'b1;
                    if (i_head.op == OP_SCHED) begin
                        n_state = ST_SCAN0;
                    end
                end
            end
            ST_SCAN0: begin
                if (last_idx) begin
                    n_state = ST_SCAN1;
                end
            end
            ST_SCAN1: begin
                if (last_idx) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ent_valid <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (accept_cmd && i_head.op == OP_DEFINE) begin
                r_ent_valid[i_head.slot] <= i_head.valid;
            end
            if (r_state == ST_SCAN0 || r_state == ST_SCAN1) begin
                r_idx <= last_idx ? '0 : r_idx + 1'b1;
            end else begin
                r_idx <= '0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // table payload and scan datapath
    always_ff @(posedge i_clk) begin
        if (accept_cmd) begin
            unique case (i_head.op)
                OP_DEFINE: begin
                    r_ent_level[i_head.slot] <= i_head.level;
                    r_ent_due[i_head.slot]   <= i_head.due;
                    r_ent_never[i_head.slot] <= i_head.never;
                    r_ent_est[i_head.slot]   <= i_head.estimate;
                end
                OP_RESCHED: begin
                    r_ent_due[i_head.slot]   <= i_head.due;
                    r_ent_never[i_head.slot] <= i_head.never;
                end
                OP_SCHED: begin
                    r_now   <= i_head.now;
                    r_have0 <= 1'b0;
                    r_have1 <= 1'b0;
                end
                default: begin
                    r_now <= r_now;
                end
            endcase
        end
        if (r_state == ST_SCAN0 && take0) begin
            r_have0  <= 1'b1;
            r_p0     <= r_idx;
            r_b0_due <= cur_due;
            r_slack  <= d_now;
        end
        if (r_state == ST_SCAN1 && take1) begin
            r_have1   <= 1'b1;
            r_p1      <= r_idx;
            r_b1_due  <= cur_due;
            r_b1_lvl  <= cur_lvl;
            r_b1_wait <= d_now;
        end
        if (load_out) begin
            r_found <= fin_found;
            r_fire  <= fin_fire;
            r_slot  <= fin_found ? SLOT_W'(r_have1 ? r_p1 : r_p0) : '0;
            r_wait  <= (fin_fire && !fin_wait[TIME_W-1]) ? fin_wait[WIN_W-1:0] : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_fire        = r_fire;
    assign o_picked_slot = r_slot;
    assign o_wait_us     = r_wait;

endmodule

// File: rtl/dpt_checker.sv
// port-level checks for the task picker, attached to the top level by bind
// depends on dpt_pkg and deadline_priority_task_picker_core
module dpt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_found,
    input logic                        o_fire,
    input logic [dpt_pkg::SLOT_W-1:0]  o_picked_slot,
    input logic [dpt_pkg::WIN_W-1:0]   o_wait_us
);
    import dpt_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // empty pick reports all zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> !o_fire && o_picked_slot == '0 && o_wait_us == '0)
        else $error("empty pick with nonzero fields");

    // no wait reported for a pick that does not fire
    a_wait_only_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_fire |-> o_wait_us == '0)
        else $error("wait reported without fire");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind deadline_priority_task_picker_core dpt_checker u_dpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_found       (o_found),
    .o_fire        (o_fire),
    .o_picked_slot (o_picked_slot),
    .o_wait_us     (o_wait_us)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for deadline_priority_task_picker_core
// sends define, reschedule and schedule requests, predicts each pick and checks it
// depends on dpt_pkg and the rtl of the core, nothing else
module tb_top;
    import dpt_pkg::*;

    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int LIMIT_CYCLES = 1000000;
    // defines still queued behind the last result finish well inside this
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 325;

    typedef struct packed {
        logic [1:0]         kind;
        logic [SLOT_W-1:0]  slot;
        logic               valid;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  due;
        logic               never;
        logic [TIME_W-1:0]  est;
        logic [TIME_W-1:0]  now;
    } task_req_t;

    typedef struct packed {
        logic              found;
        logic              fire;
        logic [SLOT_W-1:0] slot;
        logic [WIN_W-1:0]  wait_us;
    } pick_t;

    // one line of the directed part: a request, or a window write
    typedef struct packed {
        logic             is_cfg;
        logic [WIN_W-1:0] cfg_val;
        task_req_t        req;
        logic             typed;
        pick_t            res;
    } dir_row_t;

    logic                i_clk;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_kind         = '0;
    logic [SLOT_W-1:0]   i_task_slot    = '0;
    logic                i_slot_valid   = 1'b0;
    logic [LEVEL_W-1:0]  i_task_level   = '0;
    logic [TIME_W-1:0]   i_due_time     = '0;
    logic                i_due_never    = 1'b0;
    logic [TIME_W-1:0]   i_run_estimate = '0;
    logic [TIME_W-1:0]   i_current_time = '0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic                o_found;
    logic                o_fire;
    logic [SLOT_W-1:0]   o_picked_slot;
    logic [WIN_W-1:0]    o_wait_us;
    logic                i_cfg_valid    = 1'b0;
    logic                o_cfg_ready;
    logic [WIN_W-1:0]    i_cfg_data     = '0;

    // predictor copy of the task table and the window register
    logic                tbl_valid [TASK_COUNT];
    logic [LEVEL_W-1:0]  tbl_level [TASK_COUNT];
    logic [TIME_W-1:0]   tbl_due   [TASK_COUNT];
    logic                tbl_never [TASK_COUNT];
    logic [TIME_W-1:0]   tbl_est   [TASK_COUNT];
    logic [WIN_W-1:0]    fire_window = FIRE_WINDOW_RESET;

    pick_t               pending_picks [$];
    dir_row_t            dir_rows [$];
    int                  mismatches = 0;
    int                  cycle_cnt  = 0;
    int                  tx_mode    = 0;
    int                  rx_mode    = 0;
    int                  rx_hold    = 0;
    logic [TIME_W-1:0]   clock_us   = '0;

    deadline_priority_task_picker_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_task_slot    (i_task_slot),
        .i_slot_valid   (i_slot_valid),
        .i_task_level   (i_task_level),
        .i_due_time     (i_due_time),
        .i_due_never    (i_due_never),
        .i_run_estimate (i_run_estimate),
        .i_current_time (i_current_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_fire         (o_fire),
        .o_picked_slot  (o_picked_slot),
        .o_wait_us      (o_wait_us),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a result never shows up
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // wrap-aware signed distance a - b
    function automatic int time_diff(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return $signed(d);
    endfunction

    // mode 0 idles freely, mode 1 never, mode 2 now and then
    function automatic int draw_gap(input int mode);
        if (mode == 1)
            return 0;
        if (mode == 2 && $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // apply one request to the table copy; returns 1 with the pick for a schedule pass
    function automatic logic predict_pick(input task_req_t r, output pick_t res);
        logic              have0;
        logic              have1;
        int                p0;
        int                p1;
        int                sel;
        int                dly;
        int                win;
        logic [TIME_W-1:0] new_due;
        res = '0;
        case (r.kind)
            KIND_DEFINE: begin
                tbl_valid[r.slot] = r.valid;
                tbl_level[r.slot] = r.level;
                tbl_due[r.slot]   = r.due;
                tbl_never[r.slot] = r.never;
                tbl_est[r.slot]   = r.est;
                return 1'b0;
            end
            KIND_RESCHED: begin
                // a past due time is pulled up to now, never keeps it as given
                new_due = r.due;
                if (!r.never && time_diff(r.due, r.now) < 0)
                    new_due = r.now;
                tbl_due[r.slot]   = new_due;
                tbl_never[r.slot] = r.never;
                return 1'b0;
            end
            KIND_SCHEDULE: begin
                have0 = 1'b0;
                have1 = 1'b0;
                p0    = 0;
                p1    = 0;
                // earliest priority-zero deadline, lower index on a tie
                for (int i = 0; i < TASK_COUNT; i++) begin
                    if (tbl_valid[i] && !tbl_never[i] && tbl_level[i] == 0) begin
                        if (!have0 || time_diff(tbl_due[p0], tbl_due[i]) > 0) begin
                            p0    = i;
                            have0 = 1'b1;
                        end
                    end
                end
                // overdue leveled tasks that finish before that deadline
                for (int i = 0; i < TASK_COUNT; i++) begin
                    if (tbl_valid[i] && !tbl_never[i] && tbl_level[i] != 0 &&
                        time_diff(tbl_due[i], r.now) <= 0 &&
                        !(have0 && time_diff(tbl_due[p0], r.now + tbl_est[i]) <= 0)) begin
                        if (!have1 || tbl_level[p1] > tbl_level[i] ||
                            (tbl_level[p1] == tbl_level[i] &&
                             time_diff(tbl_due[p1], tbl_due[i]) > 0)) begin
                            p1    = i;
                            have1 = 1'b1;
                        end
                    end
                end
                if (have0 || have1) begin
                    sel         = have1 ? p1 : p0;
                    res.found   = 1'b1;
                    res.slot    = SLOT_W'(sel);
                    dly         = time_diff(tbl_due[sel], r.now);
                    win         = fire_window;
                    if (dly < win) begin
                        res.fire    = 1'b1;
                        res.wait_us = (dly > 0) ? dly[WIN_W-1:0] : '0;
                    end
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic task_req_t mk_req(input logic [1:0] kind, input int slot,
                                         input logic valid, input int level,
                                         input logic [TIME_W-1:0] due, input logic never,
                                         input logic [TIME_W-1:0] est,
                                         input logic [TIME_W-1:0] now);
        task_req_t r;
        r.kind  = kind;
        r.slot  = SLOT_W'(slot);
        r.valid = valid;
        r.level = LEVEL_W'(level);
        r.due   = due;
        r.never = never;
        r.est   = est;
        r.now   = now;
        return r;
    endfunction

    function automatic dir_row_t row_req(input task_req_t r);
        dir_row_t row;
        row     = '0;
        row.req = r;
        return row;
    endfunction

    function automatic dir_row_t row_typed(input task_req_t r, input logic found,
                                           input logic fire, input int slot, input int wait_us);
        dir_row_t row;
        row             = '0;
        row.req         = r;
        row.typed       = 1'b1;
        row.res.found   = found;
        row.res.fire    = fire;
        row.res.slot    = SLOT_W'(slot);
        row.res.wait_us = WIN_W'(wait_us);
        return row;
    endfunction

    function automatic dir_row_t row_cfg(input logic [WIN_W-1:0] v);
        dir_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.cfg_val = v;
        return row;
    endfunction

    // mostly coherent task traffic around a running clock, some pure noise
    function automatic task_req_t rand_req();
        task_req_t r;
        int        sel;
        int        off;
        sel     = $urandom_range(0, 99);
        off     = int'($urandom_range(0, 40000)) - 20000;
        r       = '0;
        r.now   = clock_us;
        r.slot  = SLOT_W'($urandom_range(0, TASK_COUNT - 1));
        r.due   = clock_us + TIME_W'(off);
        r.never = ($urandom_range(0, 9) == 0);
        if (sel < 10 || sel >= 97) begin
            r.kind  = 2'($urandom_range(0, 3));
            r.slot  = SLOT_W'($urandom);
            r.valid = 1'($urandom);
            r.level = LEVEL_W'($urandom);
            r.due   = $urandom;
            r.never = 1'($urandom);
            r.est   = $urandom;
            r.now   = $urandom;
            if (sel >= 97)
                r.kind = KIND_RESERVED;
        end else if (sel < 40) begin
            r.kind  = KIND_DEFINE;
            r.valid = ($urandom_range(0, 9) != 0);
            r.level = ($urandom_range(0, 4) < 2) ? '0 : LEVEL_W'($urandom_range(1, 15));
            r.est   = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 8000);
        end else if (sel < 62) begin
            r.kind = KIND_RESCHED;
        end else begin
            r.kind   = KIND_SCHEDULE;
            clock_us = clock_us + $urandom_range(0, 3000);
            r.now    = clock_us;
        end
        return r;
    endfunction

    // valid stays up into the next request when the drawn gap is zero
    task automatic send_req(input task_req_t r, input logic use_typed, input pick_t typed_res);
        pick_t res;
        int    gap;
        i_in_valid     <= 1'b1;
        i_kind         <= r.kind;
        i_task_slot    <= r.slot;
        i_slot_valid   <= r.valid;
        i_task_level   <= r.level;
        i_due_time     <= r.due;
        i_due_never    <= r.never;
        i_run_estimate <= r.est;
        i_current_time <= r.now;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_pick(r, res))
            pending_picks.push_back(use_typed ? typed_res : res);
        gap = draw_gap(tx_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every pick still owed
    task automatic drain(input int extra);
        i_in_valid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] v);
        drain(DRAIN_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        fire_window = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input pick_t want, input pick_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: found/fire/slot/wait exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     what, want.found, want.fire, want.slot, want.wait_us,
                     got.found, got.fire, got.slot, got.wait_us);
    endtask

    // result side: random stall before each pick, plus an occasional long hold
    initial begin : pick_sink
        pick_t got;
        pick_t want;
        int    n;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold > 0) begin
                n       = rx_hold;
                rx_hold = 0;
            end else begin
                n = draw_gap(rx_mode);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got = '{o_found, o_fire, o_picked_slot, o_wait_us};
            if (pending_picks.size() == 0) begin
                report_mismatch("pick with no schedule request pending", '0, got);
            end else begin
                want = pending_picks.pop_front();
                if (got != want)
                    report_mismatch("pick mismatch", want, got);
            end
        end
    end

    initial begin : stimulus
        int                ph;
        int                k;
        logic [WIN_W-1:0]  win;
        foreach (tbl_valid[s])
            tbl_valid[s] = 1'b0;

        // empty table, then window-reset picks that can be read off directly
        dir_rows.push_back(row_typed(mk_req(KIND_SCHEDULE, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0));
        dir_rows.push_back(row_req(mk_req(KIND_RESERVED, 7, 1, 15, 32'hFFFF_FFFF, 1,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF)));
        dir_rows.push_back(row_req(mk_req(KIND_DEFINE, 0, 1, 0, 1000, 0, 0, 0)));
        dir_rows.push_back(row_typed(mk_req(KIND_SCHEDULE, 0, 0, 0, 0, 0, 0, 0), 1, 1, 0, 1000));
        // overdue deadline task fires at once
        dir_rows.push_back(row_typed(mk_req(KIND_SCHEDULE, 0, 0, 0, 0, 0, 0, 2000), 1, 1, 0, 0));
        // found but outside the window, across the time wrap
        dir_rows.push_back(row_typed(mk_req(KIND_SCHEDULE, 0, 0, 0, 0, 0, 0, 32'hFFFF_F000),
                                     1, 0, 0, 0));
        // top level, top due time, top estimate
        dir_rows.push_back(row_req(mk_req(KIND_DEFINE, 7, 1, 15, 32'hFFFF_FFFF, 0,
                                          32'hFFFF_FFFF, 0)));
        dir_rows.push_back(row_req(mk_req(KIND_SCHEDULE, 0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(row_req(mk_req(KIND_DEFINE, 7, 0, 15, 0, 0, 0, 0)));
        // equal deadlines keep the lower slot
        dir_rows.push_back(row_req(mk_req(KIND_DEFINE, 3, 1, 0, 1000, 0, 5, 0)));
        dir_rows.push_back(row_typed(mk_req(KIND_SCHEDULE, 0, 0, 0, 0, 0, 0, 0), 1, 1, 0, 1000));
        // past due time is raised to now
        dir_rows.push_back(row_req(mk_req(KIND_RESCHED, 3, 0, 0, 10, 0, 0, 500)));
        dir_rows.push_back(row_req(mk_req(KIND_SCHEDULE, 0, 0, 0, 0, 0, 0, 500)));
        // reschedule to never keeps the given due time
        dir_rows.push_back(row_req(mk_req(KIND_RESCHED, 3, 0, 0, 5, 1, 0, 500)));
        // one leveled task fits before the deadline, the other does not
        dir_rows.push_back(row_req(mk_req(KIND_DEFINE, 5, 1, 2, 400, 0, 100, 0)));
        dir_rows.push_back(row_req(mk_req(KIND_DEFINE, 6, 1, 2, 300, 0, 600, 0)));
        dir_rows.push_back(row_req(mk_req(KIND_SCHEDULE, 0, 0, 0, 0, 0, 0, 500)));
        // reschedule of a slot never defined
        dir_rows.push_back(row_req(mk_req(KIND_RESCHED, 2, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(row_cfg(16'd0));
        dir_rows.push_back(row_req(mk_req(KIND_SCHEDULE, 0, 0, 0, 0, 0, 0, 400)));
        dir_rows.push_back(row_cfg(16'hFFFF));
        dir_rows.push_back(row_req(mk_req(KIND_SCHEDULE, 0, 0, 0, 0, 0, 0, 32'h8000_0000)));
        // widest wait that still fires
        dir_rows.push_back(row_req(mk_req(KIND_DEFINE, 0, 1, 0, 65534, 0, 0, 0)));
        dir_rows.push_back(row_typed(mk_req(KIND_SCHEDULE, 0, 0, 0, 0, 0, 0, 0), 1, 1, 0, 65534));

        // synchronous reset, then release
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (dir_rows[j]) begin
            if (dir_rows[j].is_cfg)
                write_window(dir_rows[j].cfg_val);
            else
                send_req(dir_rows[j].req, dir_rows[j].typed, dir_rows[j].res);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       win = 16'd0;
                1:       win = 16'hFFFF;
                2:       win = 16'd1;
                3:       win = FIRE_WINDOW_RESET;
                4:       win = WIN_W'($urandom);
                default: win = 16'd20000;
            endcase
            write_window(win);
            // first phase runs flat out on both sides
            tx_mode  = (ph == 0) ? 1 : $urandom_range(0, 2);
            rx_mode  = (ph == 0) ? 1 : $urandom_range(0, 2);
            clock_us = (ph == 3) ? 32'hFFFF_C000 : $urandom;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // long result hold while requests keep coming, fills the queue
                if (ph == 1 && k == 40) begin
                    rx_hold = 300;
                    tx_mode = 1;
                end
                if (ph == 1 && k == 120)
                    tx_mode = 0;
                // sender pause until every pick has come back
                if (ph == 2 && k == 150)
                    drain(0);
                send_req(rand_req(), 1'b0, '0);
            end
        end

        drain(100);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
